// ===== src/tsp_pkg.sv =====
package tsp_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int TS_W   = 63;
    localparam int WIN_W  = 30;
    localparam int SKEW_W = 31;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [TS_W-1:0]   t_ts;
    typedef logic [WIN_W-1:0]  t_win;

    localparam t_win WINDOW_RESET = 30'd8333333;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_PURGE_OPP,
        S_PURGE_OWN,
        S_SHIFT,
        S_APPEND,
        S_RESULT
    } t_state;

    // one store write
    typedef struct packed {
        logic  we;
        t_addr addr;
        t_ts   data;
    } t_mem_wr;

    // finished request handed to the statistics / output stage
    typedef struct packed {
        logic                     vld;
        logic                     paired;
        logic signed [SKEW_W-1:0] skew;
    } t_evt;

endpackage

// ===== src/tsp_if.sv =====
interface tsp_req_if;
    logic               valid;
    logic               ready;
    logic               side;
    logic [tsp_pkg::TS_W-1:0] timestamp;

    modport source (output valid, side, timestamp, input ready);
    modport sink   (input valid, side, timestamp, output ready);
endinterface

interface tsp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              paired;
    logic signed [tsp_pkg::SKEW_W-1:0] skew;
    logic [tsp_pkg::CNT_W-1:0]         pair_total;
    logic signed [tsp_pkg::SUM_W-1:0]  skew_sum;

    modport source (output valid, paired, skew, pair_total, skew_sum, input ready);
    modport sink   (input valid, paired, skew, pair_total, skew_sum, output ready);
endinterface

// ===== src/tsp_store.sv =====
// Both pending stores in one RAM: address = {side, entry}.
module tsp_store (
    input  logic             i_clk,
    input  tsp_pkg::t_mem_wr i_wr,
    input  tsp_pkg::t_addr   i_raddr,
    output tsp_pkg::t_ts     o_rdata
);

    tsp_pkg::t_ts r_mem [2**tsp_pkg::ADDR_W];
    tsp_pkg::t_ts r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tsp_seq.sv =====
// Sequencer: nearest search, compaction passes and append over the store RAM.
module tsp_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tsp_pkg::t_win    i_window,
    tsp_req_if.sink          i_req,
    output tsp_pkg::t_mem_wr o_wr,
    output tsp_pkg::t_addr   o_raddr,
    input  tsp_pkg::t_ts     i_mem_rdata,
    output tsp_pkg::t_evt    o_evt,
    input  logic             i_evt_ready
);

    tsp_pkg::t_state r_state, n_state;

    logic          r_side;
    tsp_pkg::t_ts  r_ts;
    tsp_pkg::t_fill r_fill_l, r_fill_r;
    tsp_pkg::t_fill r_ridx, r_widx;

    // read pipe: p1 = RAM data valid, p2 = distance registered
    logic          r_p1_vld;
    tsp_pkg::t_idx r_p1_idx;
    logic          r_p2_vld;
    tsp_pkg::t_idx r_p2_idx;
    tsp_pkg::t_ts  r_p2_dist;
    logic          r_p2_ge;
    tsp_pkg::t_ts  r_p2_val;

    logic          r_best_any;
    tsp_pkg::t_idx r_best_idx;
    tsp_pkg::t_ts  r_best_d;
    logic          r_best_ge;
    tsp_pkg::t_ts  r_best_val;

    logic                              r_paired;
    logic signed [tsp_pkg::SKEW_W-1:0] r_skew;
    tsp_pkg::t_ts                      r_cutoff;

    logic           w_scan;
    logic           w_scan_side;
    tsp_pkg::t_fill w_limit;
    tsp_pkg::t_fill w_own_fill;
    logic           w_issue;
    logic           w_scan_done;
    logic           w_keep;
    logic           w_match;
    logic           w_fire;
    logic [tsp_pkg::TS_W:0] w_dab, w_dba;
    logic           w_ge;
    tsp_pkg::t_ts   w_dist;
    logic [tsp_pkg::SKEW_W-1:0] w_d_lo;

    assign w_fire     = i_req.valid && i_req.ready;
    assign w_own_fill = r_side ? r_fill_r : r_fill_l;

    always_comb begin
        unique case (r_state)
            tsp_pkg::S_SEARCH, tsp_pkg::S_PURGE_OPP: w_scan_side = ~r_side;
            default:                                 w_scan_side = r_side;
        endcase
    end

    assign w_scan = (r_state == tsp_pkg::S_SEARCH) || (r_state == tsp_pkg::S_PURGE_OPP) ||
                    (r_state == tsp_pkg::S_PURGE_OWN) || (r_state == tsp_pkg::S_SHIFT);
    assign w_limit     = w_scan_side ? r_fill_r : r_fill_l;
    assign w_issue     = w_scan && (r_ridx < w_limit);
    assign w_scan_done = w_scan && (r_ridx == w_limit) && !r_p1_vld && !r_p2_vld;
    assign o_raddr     = {w_scan_side, r_ridx[tsp_pkg::IDX_W-1:0]};

    // distance to the incoming timestamp
    assign w_dab  = {1'b0, i_mem_rdata} - {1'b0, r_ts};
    assign w_dba  = {1'b0, r_ts} - {1'b0, i_mem_rdata};
    assign w_ge   = ~w_dab[tsp_pkg::TS_W];
    assign w_dist = w_ge ? w_dab[tsp_pkg::TS_W-1:0] : w_dba[tsp_pkg::TS_W-1:0];

    assign w_match = r_best_any &&
                     (r_best_d <= {{(tsp_pkg::TS_W - tsp_pkg::WIN_W){1'b0}}, i_window});
    assign w_d_lo  = r_best_d[tsp_pkg::SKEW_W-1:0];

    always_comb begin
        unique case (r_state)
            tsp_pkg::S_PURGE_OPP: w_keep = (r_p1_idx != r_best_idx) &&
                                           (i_mem_rdata >= r_cutoff);
            tsp_pkg::S_PURGE_OWN: w_keep = (i_mem_rdata >= r_cutoff);
            tsp_pkg::S_SHIFT:     w_keep = (r_p1_idx != '0);
            default:              w_keep = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        o_evt.vld   = 1'b0;
        o_evt.paired = r_paired;
        o_evt.skew  = r_skew;
        o_wr.we     = r_p1_vld && w_keep;
        o_wr.addr   = {w_scan_side, r_widx[tsp_pkg::IDX_W-1:0]};
        o_wr.data   = i_mem_rdata;
        unique case (r_state)
            tsp_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = tsp_pkg::S_SEARCH;
                end
            end
            tsp_pkg::S_SEARCH: begin
                if (w_scan_done) begin
                    n_state = tsp_pkg::S_DECIDE;
                end
            end
            tsp_pkg::S_DECIDE: begin
                if (w_match) begin
                    n_state = tsp_pkg::S_PURGE_OPP;
                end else if (w_own_fill == tsp_pkg::t_fill'(tsp_pkg::DEPTH)) begin
                    n_state = tsp_pkg::S_SHIFT;
                end else begin
                    n_state = tsp_pkg::S_APPEND;
                end
            end
            tsp_pkg::S_PURGE_OPP: begin
                if (w_scan_done) begin
                    n_state = tsp_pkg::S_PURGE_OWN;
                end
            end
            tsp_pkg::S_PURGE_OWN: begin
                if (w_scan_done) begin
                    n_state = tsp_pkg::S_RESULT;
                end
            end
            tsp_pkg::S_SHIFT: begin
                if (w_scan_done) begin
                    n_state = tsp_pkg::S_APPEND;
                end
            end
            tsp_pkg::S_APPEND: begin
                o_wr.we   = 1'b1;
                o_wr.addr = {r_side, w_own_fill[tsp_pkg::IDX_W-1:0]};
                o_wr.data = r_ts;
                n_state   = tsp_pkg::S_RESULT;
            end
            tsp_pkg::S_RESULT: begin
                o_evt.vld = 1'b1;
                if (i_evt_ready) begin
                    n_state = tsp_pkg::S_IDLE;
                end
            end
            default: n_state = tsp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_side <= i_req.side;
            r_ts   <= i_req.timestamp;
        end
        r_p1_idx  <= r_ridx[tsp_pkg::IDX_W-1:0];
        r_p2_idx  <= r_p1_idx;
        r_p2_dist <= w_dist;
        r_p2_ge   <= w_ge;
        r_p2_val  <= i_mem_rdata;
        if (r_p2_vld && (!r_best_any || (r_p2_dist < r_best_d))) begin
            r_best_idx <= r_p2_idx;
            r_best_d   <= r_p2_dist;
            r_best_ge  <= r_p2_ge;
            r_best_val <= r_p2_val;
        end
        if (r_state == tsp_pkg::S_DECIDE) begin
            r_cutoff <= r_best_ge ? r_ts : r_best_val;
            if (!w_match) begin
                r_skew <= '0;
            end else if (r_best_ge ^ r_side) begin
                r_skew <= w_d_lo;
            end else begin
                r_skew <= -w_d_lo;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_l   <= '0;
            r_fill_r   <= '0;
            r_ridx     <= '0;
            r_widx     <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_best_any <= 1'b0;
            r_paired   <= 1'b0;
        end else begin
            r_p1_vld <= w_issue;
            r_p2_vld <= r_p1_vld && (r_state == tsp_pkg::S_SEARCH);
            if (w_issue) begin
                r_ridx <= r_ridx + tsp_pkg::t_fill'(1);
            end
            if (o_wr.we && (r_state != tsp_pkg::S_APPEND)) begin
                r_widx <= r_widx + tsp_pkg::t_fill'(1);
            end
            if (r_p2_vld) begin
                r_best_any <= 1'b1;
            end
            if (w_fire) begin
                r_ridx     <= '0;
                r_widx     <= '0;
                r_best_any <= 1'b0;
            end
            if (r_state == tsp_pkg::S_DECIDE) begin
                r_paired <= w_match;
                r_ridx   <= '0;
                r_widx   <= '0;
            end
            if (w_scan_done) begin
                r_ridx <= '0;
                r_widx <= '0;
                if (w_scan_side) begin
                    if (r_state != tsp_pkg::S_SEARCH) r_fill_r <= r_widx;
                end else begin
                    if (r_state != tsp_pkg::S_SEARCH) r_fill_l <= r_widx;
                end
            end
            if (r_state == tsp_pkg::S_APPEND) begin
                if (r_side) begin
                    r_fill_r <= r_fill_r + tsp_pkg::t_fill'(1);
                end else begin
                    r_fill_l <= r_fill_l + tsp_pkg::t_fill'(1);
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_l <= tsp_pkg::t_fill'(tsp_pkg::DEPTH)) &&
        (r_fill_r <= tsp_pkg::t_fill'(tsp_pkg::DEPTH)))
        else $error("pending store fill above depth");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.we && (r_state != tsp_pkg::S_APPEND)) |-> (r_widx <= tsp_pkg::t_fill'(r_p1_idx)))
        else $error("compaction write ahead of read");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsp_pkg::S_APPEND) |-> (w_own_fill < tsp_pkg::t_fill'(tsp_pkg::DEPTH)))
        else $error("append into full store");

endmodule

// ===== src/tsp_stats.sv =====
// Saturating pair count / skew sum and the output register.
module tsp_stats (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsp_pkg::t_evt i_evt,
    output logic          o_evt_ready,
    tsp_rsp_if.source     o_rsp
);

    logic                              r_vld;
    logic                              r_paired;
    logic signed [tsp_pkg::SKEW_W-1:0] r_skew;
    logic [tsp_pkg::CNT_W-1:0]         r_pair_count;
    logic [tsp_pkg::SUM_W-1:0]         r_skew_total;

    logic                      w_push;
    logic [tsp_pkg::SUM_W-1:0] w_skew_ext;
    logic [tsp_pkg::SUM_W-1:0] w_sum;
    logic                      w_ovf;
    logic [tsp_pkg::SUM_W-1:0] n_skew_total;
    logic [tsp_pkg::CNT_W-1:0] n_pair_count;

    assign o_evt_ready = !r_vld || o_rsp.ready;
    assign w_push      = i_evt.vld && o_evt_ready;

    assign w_skew_ext = {{(tsp_pkg::SUM_W - tsp_pkg::SKEW_W){i_evt.skew[tsp_pkg::SKEW_W-1]}},
                         i_evt.skew};
    assign w_sum = r_skew_total + w_skew_ext;
    assign w_ovf = (r_skew_total[tsp_pkg::SUM_W-1] == w_skew_ext[tsp_pkg::SUM_W-1]) &&
                   (w_sum[tsp_pkg::SUM_W-1] != r_skew_total[tsp_pkg::SUM_W-1]);

    always_comb begin
        if (!w_ovf) begin
            n_skew_total = w_sum;
        end else if (w_skew_ext[tsp_pkg::SUM_W-1]) begin
            n_skew_total = {1'b1, {(tsp_pkg::SUM_W-1){1'b0}}};
        end else begin
            n_skew_total = {1'b0, {(tsp_pkg::SUM_W-1){1'b1}}};
        end
        if (i_evt.paired && (r_pair_count != '1)) begin
            n_pair_count = r_pair_count + tsp_pkg::CNT_W'(1);
        end else begin
            n_pair_count = r_pair_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_paired <= i_evt.paired;
            r_skew   <= i_evt.skew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_pair_count <= '0;
            r_skew_total <= '0;
        end else begin
            if (w_push) begin
                r_vld        <= 1'b1;
                r_pair_count <= n_pair_count;
                r_skew_total <= n_skew_total;
            end else if (o_rsp.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_vld;
    assign o_rsp.paired     = r_paired;
    assign o_rsp.skew       = r_skew;
    assign o_rsp.pair_total = r_pair_count;
    assign o_rsp.skew_sum   = r_skew_total;

    a_skew_zero_unpaired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.paired) |-> (o_rsp.skew == '0))
        else $error("nonzero skew on unpaired result");

    a_count_after_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && i_evt.paired) |=> (r_pair_count != '0))
        else $error("pair count zero after a pair");

endmodule

// ===== src/stereo_timestamp_pairing.sv =====
// Stereo timestamp pairing: matches each frame timestamp with the nearest
// pending timestamp of the other camera.
// Channels: i_req (side, timestamp) in, o_rsp (paired, skew, pair_total,
// skew_sum) out, both valid/ready; a request moves when valid and ready are
// high at a rising edge. i_cfg_we/i_cfg_wdata write match_window; write it
// only while no request is in flight.
// One request at a time. Its work is a set of passes over the store RAM
// (one entry per cycle). A pairing request is accepted, searches the
// opposite store, decides, purges the opposite store and then the own
// store and gives its result; a non-pairing one is accepted, searches,
// decides, shifts out the oldest own entry when the own store is full,
// appends and gives its result. The result reaches o_rsp through the
// output register. i_req.ready is high only while idle.
// Reset (synchronous, active low) empties both stores by clearing their
// fill counts, zeroes pair count and skew sum and reloads the window.
// The result sits in an output register; while the receiver stalls, the
// next request is still taken and worked on, and it waits at the end
// until the register frees up.
module stereo_timestamp_pairing (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  tsp_pkg::t_win i_cfg_wdata,
    tsp_req_if.sink       i_req,
    tsp_rsp_if.source     o_rsp
);

    tsp_pkg::t_win    r_match_window;
    tsp_pkg::t_mem_wr w_wr;
    tsp_pkg::t_addr   w_raddr;
    tsp_pkg::t_ts     w_rdata;
    tsp_pkg::t_evt    w_evt;
    logic             w_evt_ready;

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_window <= tsp_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_match_window <= i_cfg_wdata;
        end
    end

    // left and right pending stores, oldest entry first
    tsp_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // search, purge/evict passes, append
    tsp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_match_window),
        .i_req       (i_req),
        .o_wr        (w_wr),
        .o_raddr     (w_raddr),
        .i_mem_rdata (w_rdata),
        .o_evt       (w_evt),
        .i_evt_ready (w_evt_ready)
    );

    // running totals and output register
    tsp_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .o_evt_ready (w_evt_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // Clock period is 20 ns; the run is cut off after TIMEOUT_NS.
    localparam int   HALF_PERIOD     = 10;
    localparam int   TIMEOUT_NS      = 20_000_000;
    // Idle wait before a window write and before the final verdict, long
    // enough for a request to be worked on to the end.
    localparam int   DRAIN_CYCLES    = 80;
    // Long receiver hold-off: the block takes one request, finishes it,
    // takes the next and then must stall its input.
    localparam int   HOLD_OFF_CYCLES = 500;
    localparam int   PHASE_ITEMS     = 330;
    localparam tsp_pkg::t_ts  TS_MAX  = {tsp_pkg::TS_W{1'b1}};
    localparam tsp_pkg::t_win WIN_MAX = {tsp_pkg::WIN_W{1'b1}};

    // One result as the block reports it.
    typedef struct packed {
        logic                              paired;
        logic signed [tsp_pkg::SKEW_W-1:0] skew;
        logic [tsp_pkg::CNT_W-1:0]         total;
        logic signed [tsp_pkg::SUM_W-1:0]  sum;
    } t_pair_result;

    // One queued frame of the random stream.
    typedef struct packed {
        logic         side;
        tsp_pkg::t_ts ts;
    } t_frame;

    // Directed script: a frame, or a window write (value in ts).
    typedef enum bit {
        ROW_FRAME,
        ROW_WINDOW
    } t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic                              side;
        tsp_pkg::t_ts                      ts;
        logic                              checked;
        logic                              paired;
        logic signed [tsp_pkg::SKEW_W-1:0] skew;
        logic [tsp_pkg::CNT_W-1:0]         total;
        logic signed [tsp_pkg::SUM_W-1:0]  sum;
    } t_script_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    tsp_pkg::t_win i_cfg_wdata;

    tsp_req_if     req_bus ();
    tsp_rsp_if     rsp_bus ();

    stereo_timestamp_pairing u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the pairing state, indexed by side (0 left, 1 right).
    // Stores are kept oldest first; only the first pend_cnt entries count.
    // ------------------------------------------------------------------
    tsp_pkg::t_ts                     pend_ts [2][tsp_pkg::DEPTH];
    int                               pend_cnt [2]   = '{0, 0};
    logic [tsp_pkg::CNT_W-1:0]        pair_count     = '0;
    logic signed [tsp_pkg::SUM_W-1:0] skew_total     = '0;
    tsp_pkg::t_win                    window_model   = tsp_pkg::WINDOW_RESET;

    t_pair_result            expected_pairings[$];
    t_frame                  frame_q[$];
    int                      frames_accepted   = 0;
    int                      frames_checked    = 0;
    int                      mismatches        = 0;
    int                      send_idle_pct     = 27;
    int                      recv_idle_pct     = 88;
    int                      hold_off_requests = 0;
    int                      hold_off_served   = 0;
    t_pair_result            due;

    // Directed part. Typed expectations only where they are obvious:
    // right after reset, at the window edge and at the timestamp extremes.
    t_script_row demo_rows [22] = '{
        // empty opposite store after reset: stored, nothing paired yet
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd0,           1'b1, 1'b0, 31'sd0, 32'd0, 64'sd0},
        // difference exactly at the reset window pairs
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd8_333_333,   1'b1, 1'b1, 31'sd8_333_333, 32'd1,
          64'sd8_333_333},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd8_333_334,   1'b1, 1'b0, 31'sd0, 32'd1,
          64'sd8_333_333},
        // one past the window: no pair
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd0,           1'b1, 1'b0, 31'sd0, 32'd1,
          64'sd8_333_333},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, TS_MAX,          1'b1, 1'b0, 31'sd0, 32'd1,
          64'sd8_333_333},
        // top timestamp pairs with skew 0 and purges everything else
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  TS_MAX,          1'b1, 1'b1, 31'sd0, 32'd2,
          64'sd8_333_333},
        // negative skew
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd50_000_000,  1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd49_999_000,  1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        // two right entries equally far: the older one wins
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd100_000_000, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd100_000_200, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd100_000_100, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        // pairing at 300 ms purges stale entries on both sides
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd200_000_000, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd300_000_000, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd300_000_050, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        // zero window: only equal timestamps pair
        '{ROW_WINDOW, tsp_pkg::SIDE_LEFT,  63'd0,           1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd400_000_000, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd400_000_000, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd400_000_001, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd400_000_002, 1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        // widest window: pairs at the window edge, skew of either sign
        '{ROW_WINDOW, tsp_pkg::SIDE_LEFT,  63'(WIN_MAX),    1'b0, 1'b0, 31'sd0, 32'd0, 64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_LEFT,  63'd1_473_741_824, 1'b0, 1'b0, 31'sd0, 32'd0,
          64'sd0},
        '{ROW_FRAME,  tsp_pkg::SIDE_RIGHT, 63'd1_473_741_825, 1'b0, 1'b0, 31'sd0, 32'd0,
          64'sd0}
    };

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("stereo_timestamp_pairing test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: nearest opposite entry, oldest on ties; pair if within the
    // window and purge older entries, else append to own store with oldest-first eviction.
    // ------------------------------------------------------------------
    function automatic t_pair_result predict_pairing(input logic side,
                                                     input tsp_pkg::t_ts ts);
        t_pair_result                     res;
        int                               own;
        int                               opp;
        int                               best;
        int                               wr;
        tsp_pkg::t_ts                     best_d;
        tsp_pkg::t_ts                     d;
        tsp_pkg::t_ts                     other;
        tsp_pkg::t_ts                     cutoff;
        logic signed [tsp_pkg::SUM_W-1:0] skew64;
        logic signed [tsp_pkg::SUM_W:0]   wide;

        res  = '0;
        own  = (side == tsp_pkg::SIDE_RIGHT) ? 1 : 0;
        opp  = 1 - own;
        if (pend_cnt[opp] > 0) begin
            best   = 0;
            best_d = '1;
            for (int i = 0; i < pend_cnt[opp]; i++) begin
                d = (pend_ts[opp][i] > ts) ? pend_ts[opp][i] - ts : ts - pend_ts[opp][i];
                if (d < best_d) begin
                    best_d = d;
                    best   = i;
                end
            end
            if (best_d <= tsp_pkg::t_ts'(window_model)) begin
                other  = pend_ts[opp][best];
                cutoff = (other < ts) ? other : ts;
                // skew is always right minus left
                if (side == tsp_pkg::SIDE_RIGHT) begin
                    skew64 = $signed({1'b0, ts}) - $signed({1'b0, other});
                end else begin
                    skew64 = $signed({1'b0, other}) - $signed({1'b0, ts});
                end
                for (int i = best; i + 1 < pend_cnt[opp]; i++) begin
                    pend_ts[opp][i] = pend_ts[opp][i + 1];
                end
                pend_cnt[opp]--;
                // drop everything older than the earlier of the two
                for (int s = 0; s < 2; s++) begin
                    wr = 0;
                    for (int r = 0; r < pend_cnt[s]; r++) begin
                        if (pend_ts[s][r] >= cutoff) begin
                            pend_ts[s][wr] = pend_ts[s][r];
                            wr++;
                        end
                    end
                    pend_cnt[s] = wr;
                end
                if (pair_count != '1) begin
                    pair_count++;
                end
                wide = {skew_total[tsp_pkg::SUM_W-1], skew_total} +
                       {skew64[tsp_pkg::SUM_W-1], skew64};
                if (wide[tsp_pkg::SUM_W] != wide[tsp_pkg::SUM_W-1]) begin
                    skew_total = wide[tsp_pkg::SUM_W] ? {1'b1, {(tsp_pkg::SUM_W-1){1'b0}}}
                                                      : {1'b0, {(tsp_pkg::SUM_W-1){1'b1}}};
                end else begin
                    skew_total = wide[tsp_pkg::SUM_W-1:0];
                end
                res.paired = 1'b1;
                res.skew   = skew64[tsp_pkg::SKEW_W-1:0];
            end
        end
        if (!res.paired) begin
            // full store: oldest goes, newest is appended
            if (pend_cnt[own] >= tsp_pkg::DEPTH) begin
                for (int i = 0; i + 1 < tsp_pkg::DEPTH; i++) begin
                    pend_ts[own][i] = pend_ts[own][i + 1];
                end
                pend_cnt[own] = tsp_pkg::DEPTH - 1;
            end
            pend_ts[own][pend_cnt[own]] = ts;
            pend_cnt[own]++;
        end
        res.total = pair_count;
        res.sum   = skew_total;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge; returns at the falling edge
    // after acceptance with valid still high, so a back-to-back request
    // never sees valid lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_frame(input logic side, input tsp_pkg::t_ts ts, input logic checked,
                              input t_pair_result typed_res);
        t_pair_result predicted;

        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.side      <= side;
        req_bus.timestamp <= ts;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        // predictor always runs so its state follows the block
        predicted = predict_pairing(side, ts);
        expected_pairings.insert(expected_pairings.size(), checked ? typed_res : predicted);
        frames_accepted++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain_requests();
        req_bus.valid <= 1'b0;
        wait (frames_checked == frames_accepted);
        @(negedge i_clk);
    endtask

    task automatic set_window(input tsp_pkg::t_win value);
        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        window_model = value;
    endtask

    // One burst of camera frames: period well above the window, right frame
    // offset from the left one mostly inside the window, sometimes exactly at
    // it or past it; single frames dropped now and then, and sometimes one
    // camera silent for the whole burst so the other store can overflow.
    task automatic plan_frames();
        int           frames;
        int           solo;
        int           pick;
        int unsigned  wu;
        longint       wl;
        longint       offset;
        tsp_pkg::t_ts period;
        tsp_pkg::t_ts top;
        tsp_pkg::t_ts base;
        tsp_pkg::t_ts left_ts;
        tsp_pkg::t_ts right_ts;
        logic         left_first;
        logic         drop_left;
        logic         drop_right;

        wu     = {2'b00, window_model};
        wl     = longint'(wu);
        frames = $urandom_range(4, 40);
        period = 3 * tsp_pkg::t_ts'(wu) + 3000 + tsp_pkg::t_ts'($urandom_range(0, 5000));
        top    = TS_MAX - tsp_pkg::t_ts'(frames + 2) * period;
        base   = tsp_pkg::t_ts'({$urandom, $urandom});
        pick   = $urandom_range(0, 9);
        if (pick == 0) begin
            base = tsp_pkg::t_ts'($urandom_range(0, 1000));
        end else if (pick == 1 || base > top) begin
            base = top - tsp_pkg::t_ts'($urandom_range(0, 1000));
        end
        solo = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0;
        for (int k = 0; k < frames; k++) begin
            left_ts = base + tsp_pkg::t_ts'(k) * period + tsp_pkg::t_ts'(wu) + 1000
                      + tsp_pkg::t_ts'($urandom_range(0, 999));
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                offset = longint'($urandom_range(0, 2 * wu)) - wl;
            end else if (pick < 80) begin
                offset = $urandom_range(0, 1) ? wl : -wl;
            end else if (pick < 95) begin
                offset = wl + 1 + longint'($urandom_range(0, wu));
                if ($urandom_range(0, 1)) offset = -offset;
            end else begin
                offset = 0;
            end
            right_ts   = (offset >= 0) ? left_ts + tsp_pkg::t_ts'(offset)
                                       : left_ts - tsp_pkg::t_ts'(-offset);
            left_first = 1'($urandom_range(0, 1));
            drop_left  = (solo == 2) || (solo == 0 && $urandom_range(0, 99) < 8);
            drop_right = (solo == 1) || (solo == 0 && $urandom_range(0, 99) < 8);
            if (left_first && !drop_left)
                frame_q.insert(frame_q.size(), t_frame'{tsp_pkg::SIDE_LEFT, left_ts});
            if (!drop_right)
                frame_q.insert(frame_q.size(), t_frame'{tsp_pkg::SIDE_RIGHT, right_ts});
            if (!left_first && !drop_left)
                frame_q.insert(frame_q.size(), t_frame'{tsp_pkg::SIDE_LEFT, left_ts});
        end
    endtask

    // Random phase; about one request in ten is pure noise.
    task automatic run_phase(input tsp_pkg::t_win win, input int s_pct, input int r_pct,
                             input int hold_at, input int drain_at);
        t_frame fr;

        set_window(win);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        frame_q.delete();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == hold_at) hold_off_requests++;
            if (n == drain_at) drain_requests();
            if ($urandom_range(0, 99) < 10) begin
                fr.side = 1'($urandom_range(0, 1));
                fr.ts   = tsp_pkg::t_ts'({$urandom, $urandom});
            end else begin
                if (frame_q.size() == 0) plan_frames();
                fr = frame_q.pop_front();
            end
            send_frame(fr.side, fr.ts, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: ready changes on the falling edge; a long hold-off is
    // timed here when the request side asks for one.
    // ------------------------------------------------------------------
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_served != hold_off_requests) begin
                hold_off_served = hold_off_requests;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Results are checked in order against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pairings.size() == 0) begin
                report_mismatch("unexpected result, pair_total", 64'(rsp_bus.pair_total), '0);
            end else begin
                due = expected_pairings.pop_front();
                frames_checked++;
                if (rsp_bus.paired !== due.paired)
                    report_mismatch("paired", 64'(rsp_bus.paired), 64'(due.paired));
                if (rsp_bus.skew !== due.skew)
                    report_mismatch("skew", 64'(rsp_bus.skew), 64'(due.skew));
                if (rsp_bus.pair_total !== due.total)
                    report_mismatch("pair_total", 64'(rsp_bus.pair_total), 64'(due.total));
                if (rsp_bus.skew_sum !== due.sum)
                    report_mismatch("skew_sum", rsp_bus.skew_sum, due.sum);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = tsp_pkg::WINDOW_RESET;
        req_bus.valid     = 1'b0;
        req_bus.side      = tsp_pkg::SIDE_LEFT;
        req_bus.timestamp = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (demo_rows[i]) begin
            if (demo_rows[i].kind == ROW_WINDOW) begin
                set_window(tsp_pkg::t_win'(demo_rows[i].ts));
            end else begin
                send_frame(demo_rows[i].side, demo_rows[i].ts, demo_rows[i].checked,
                           t_pair_result'({demo_rows[i].paired, demo_rows[i].skew,
                                           demo_rows[i].total, demo_rows[i].sum}));
            end
        end

        // slow sender / very slow receiver, back to reset window, one pause
        run_phase(tsp_pkg::WINDOW_RESET, 27, 88, -1, 150);
        // very slow sender / slow receiver, wide random window
        run_phase(tsp_pkg::t_win'($urandom_range(1, WIN_MAX - 1)), 88, 27, -1, -1);
        // no idling; long receiver hold-off fills the block, then a pause
        run_phase(tsp_pkg::t_win'($urandom_range(0, 2000)), 0, 0, 40, 200);

        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_pairings.size() == 0) begin
            $display("stereo_timestamp_pairing test passed");
        end else begin
            $display("stereo_timestamp_pairing test failed");
        end
        $finish;
    end

endmodule
